// ===== hdl/wfc_pkg.sv =====
package wfc_pkg;

    // Receiver class codes
    localparam logic [1:0] CLS_MGMT = 2'd0;
    localparam logic [1:0] CLS_DATA = 2'd2;

    // Frame control type and subtype codes
    localparam logic [1:0] FTYPE_MGMT      = 2'd0;
    localparam logic [1:0] FTYPE_DATA      = 2'd2;
    localparam logic [3:0] SUB_PROBE_REQ   = 4'd4;
    localparam logic [3:0] SUB_PROBE_RESP  = 4'd5;
    localparam logic [3:0] SUB_BEACON      = 4'd8;
    localparam logic [3:0] SUB_DISASSOC    = 4'd10;
    localparam logic [3:0] SUB_DEAUTH      = 4'd12;

    // Tagged element id of the SSID
    localparam logic [7:0] ELEM_ID_SSID = 8'd0;

    // Byte offsets within the frame
    localparam int HDR_MIN_LEN   = 24;
    localparam int PROBE_REQ_IES = 24;
    localparam int BEACON_IES    = 36;
    localparam int ADDR1_OFS     = 4;
    localparam int ADDR2_OFS     = 10;
    localparam int ADDR3_OFS     = 16;
    localparam int ADDR_END      = 22;

    typedef enum logic [1:0] {
        KIND_PROBE_REQ = 2'd0,
        KIND_BEACON    = 2'd1,
        KIND_DEAUTH    = 2'd2,
        KIND_DATA      = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_READ,
        ST_SHOW
    } emit_state_t;

    // Frame summary handed from the byte parser to the result sequencer
    typedef struct packed {
        logic [15:0]        fc;
        logic [47:0]        addr1;
        logic [47:0]        addr2;
        logic [47:0]        addr3;
        logic [1:0]         cls;
        logic signed [7:0]  rssi;
        logic [7:0]         chan;
        logic               len_ok;
        logic               ssid_fit;
        logic [5:0]         ssid_n;
    } frame_sum_t;

    // One result item
    typedef struct packed {
        kind_t              kind;
        logic signed [7:0]  sig_dbm;
        logic [7:0]         radio_chan;
        logic [47:0]        ap_mac;
        logic [47:0]        client_mac;
        logic [5:0]         ssid_len;
        logic [4:0]         ssid_pos;
        logic [7:0]         ssid_byte;
        logic               run_last;
    } result_t;

endpackage

// ===== hdl/wfc_ram.sv =====
module wfc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/wfc_parser.sv =====
module wfc_parser
    import wfc_pkg::*;
#(
    parameter int SSID_MAX        = 32,
    parameter int MAX_FRAME_BYTES = 4095,
    parameter int AW              = (SSID_MAX > 1) ? $clog2(SSID_MAX) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,        // byte request accepted
    input  logic [7:0]        data_byte,
    input  logic [1:0]        pkt_class,
    input  logic signed [7:0] rssi,
    input  logic [7:0]        channel,
    input  logic              clear,       // end of frame handling
    output frame_sum_t        sum,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [7:0]        wr_data
);

    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int EW = $clog2(MAX_FRAME_BYTES + 256);

    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [EW-1:0]     elem_next_reg, elem_next_next;
    logic [7:0]        hdr_id_reg, hdr_id_next;
    logic [7:0]        hdr_len_reg, hdr_len_next;
    logic              found_reg, found_next;
    logic [15:0]       fc_reg, fc_next;
    logic [47:0]       addr_reg [3];
    logic [47:0]       addr_next [3];
    logic [1:0]        cls_reg, cls_next;
    logic signed [7:0] rssi_reg, rssi_next;
    logic [7:0]        chan_reg, chan_next;

    logic          store;
    logic [EW-1:0] pos_e;
    logic [EW-1:0] off;
    logic [7:0]    lim;
    logic [1:0]    addr_sel;
    logic [EW:0]   ssid_end;

    always_comb
    begin
        store = take && (cnt_reg < CW'(MAX_FRAME_BYTES));
        pos_e = EW'(cnt_reg);
        off   = pos_e - elem_next_reg;
        lim   = (hdr_len_reg > 8'(SSID_MAX)) ? 8'(SSID_MAX) : hdr_len_reg;

        if (cnt_reg < CW'(ADDR2_OFS))
        begin
            addr_sel = 2'd0;
        end
        else if (cnt_reg < CW'(ADDR3_OFS))
        begin
            addr_sel = 2'd1;
        end
        else
        begin
            addr_sel = 2'd2;
        end

        cnt_next       = cnt_reg;
        elem_next_next = elem_next_reg;
        hdr_id_next    = hdr_id_reg;
        hdr_len_next   = hdr_len_reg;
        found_next     = found_reg;
        fc_next        = fc_reg;
        addr_next      = addr_reg;
        cls_next       = cls_reg;
        rssi_next      = rssi_reg;
        chan_next      = chan_reg;
        wr_en          = 1'b0;
        wr_addr        = off[AW-1:0];
        wr_data        = data_byte;

        // Latch receive metadata on the first byte
        if (take && cnt_reg == '0)
        begin
            cls_next  = pkt_class;
            rssi_next = rssi;
            chan_next = channel;
        end

        if (store)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == '0)
            begin
                fc_next      = {fc_reg[15:8], data_byte};
                found_next   = 1'b0;
                hdr_id_next  = '0;
                hdr_len_next = '0;
                if (data_byte[7:4] == SUB_PROBE_REQ)
                begin
                    elem_next_next = EW'(PROBE_REQ_IES);
                end
                else if (data_byte[7:4] == SUB_PROBE_RESP || data_byte[7:4] == SUB_BEACON)
                begin
                    elem_next_next = EW'(BEACON_IES);
                end
                else
                begin
                    elem_next_next = '0;
                end
            end
            else
            begin
                if (cnt_reg == CW'(1))
                begin
                    fc_next = {data_byte, fc_reg[7:0]};
                end
                // Walk the tagged elements until the SSID turns up
                if (!found_reg)
                begin
                    if (elem_next_reg != '0)
                    begin
                        if (pos_e == elem_next_reg)
                        begin
                            hdr_id_next  = data_byte;
                            hdr_len_next = '0;
                        end
                        else if (pos_e == elem_next_reg + 1'b1)
                        begin
                            hdr_len_next = data_byte;
                            if (hdr_id_reg == ELEM_ID_SSID)
                            begin
                                found_next     = 1'b1;
                                elem_next_next = pos_e + 1'b1;
                            end
                            else
                            begin
                                elem_next_next = pos_e + 1'b1 + EW'(data_byte);
                            end
                        end
                    end
                end
                else if (pos_e >= elem_next_reg && off < EW'(lim))
                begin
                    wr_en = 1'b1;
                end
            end

            if (cnt_reg >= CW'(ADDR1_OFS) && cnt_reg < CW'(ADDR_END))
            begin
                addr_next[addr_sel] = {addr_reg[addr_sel][39:0], data_byte};
            end
        end

        if (clear)
        begin
            cnt_next       = '0;
            elem_next_next = '0;
            hdr_id_next    = '0;
            hdr_len_next   = '0;
            found_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            elem_next_reg <= '0;
            hdr_id_reg    <= '0;
            hdr_len_reg   <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            elem_next_reg <= elem_next_next;
            hdr_id_reg    <= hdr_id_next;
            hdr_len_reg   <= hdr_len_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fc_reg   <= fc_next;
        addr_reg <= addr_next;
        cls_reg  <= cls_next;
        rssi_reg <= rssi_next;
        chan_reg <= chan_next;
    end

    assign ssid_end = {1'b0, elem_next_reg} + (EW+1)'(hdr_len_reg);

    always_comb
    begin
        sum.fc       = fc_reg;
        sum.addr1    = addr_reg[0];
        sum.addr2    = addr_reg[1];
        sum.addr3    = addr_reg[2];
        sum.cls      = cls_reg;
        sum.rssi     = rssi_reg;
        sum.chan     = chan_reg;
        sum.len_ok   = cnt_reg >= CW'(HDR_MIN_LEN);
        sum.ssid_fit = found_reg && (ssid_end <= (EW+1)'(cnt_reg));
        sum.ssid_n   = 6'(lim);
    end

endmodule

// ===== hdl/wfc_emitter.sv =====
module wfc_emitter
    import wfc_pkg::*;
#(
    parameter int SSID_MAX = 32,
    parameter int AW       = (SSID_MAX > 1) ? $clog2(SSID_MAX) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          frame_done,  // last byte request accepted
    input  frame_sum_t    sum,
    input  logic [7:0]    rd_data,
    input  logic          out_ready,
    output logic          in_ready,
    output logic          clear,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    output logic          out_valid,
    output result_t       res
);

    emit_state_t       state_reg, state_next;
    logic [5:0]        idx_reg, idx_next;
    kind_t             kind_reg, kind_next;
    logic [47:0]       ap_reg, ap_next;
    logic [47:0]       cl_reg, cl_next;
    logic [5:0]        n_reg, n_next;
    logic signed [7:0] sig_reg, sig_next;
    logic [7:0]        chan_reg, chan_next;

    logic        hit;
    kind_t       kind_c;
    logic [47:0] ap_c;
    logic [47:0] cl_c;
    logic [1:0]  ftype;
    logic [3:0]  sub;
    logic        to_ds;
    logic        from_ds;
    logic        is_last;

    // Classify the finished frame from its header
    always_comb
    begin
        ftype   = sum.fc[3:2];
        sub     = sum.fc[7:4];
        to_ds   = sum.fc[8];
        from_ds = sum.fc[9];
        hit     = 1'b0;
        kind_c  = KIND_PROBE_REQ;
        ap_c    = '0;
        cl_c    = '0;
        if ((sum.cls == CLS_MGMT || sum.cls == CLS_DATA) && sum.len_ok)
        begin
            if (ftype == FTYPE_MGMT)
            begin
                if (sub == SUB_PROBE_REQ)
                begin
                    hit    = 1'b1;
                    kind_c = KIND_PROBE_REQ;
                    cl_c   = sum.addr2;
                end
                else if (sub == SUB_PROBE_RESP || sub == SUB_BEACON)
                begin
                    hit    = 1'b1;
                    kind_c = KIND_BEACON;
                    ap_c   = sum.addr3;
                end
                else if (sub == SUB_DISASSOC || sub == SUB_DEAUTH)
                begin
                    hit    = 1'b1;
                    kind_c = KIND_DEAUTH;
                    ap_c   = sum.addr2;
                end
            end
            else if (ftype == FTYPE_DATA)
            begin
                if (to_ds && !from_ds)
                begin
                    hit    = 1'b1;
                    kind_c = KIND_DATA;
                    ap_c   = sum.addr1;
                    cl_c   = sum.addr2;
                end
                else if (!to_ds && from_ds)
                begin
                    hit    = 1'b1;
                    kind_c = KIND_DATA;
                    ap_c   = sum.addr2;
                    cl_c   = sum.addr1;
                end
            end
        end
    end

    assign is_last = ({1'b0, idx_reg} + 7'd1) >= {1'b0, n_reg};

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        kind_next  = kind_reg;
        ap_next    = ap_reg;
        cl_next    = cl_reg;
        n_next     = n_reg;
        sig_next   = sig_reg;
        chan_next  = chan_reg;
        in_ready   = 1'b0;
        clear      = 1'b0;
        rd_en      = 1'b0;
        out_valid  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (frame_done)
                begin
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                clear     = 1'b1;
                idx_next  = '0;
                kind_next = kind_c;
                ap_next   = ap_c;
                cl_next   = cl_c;
                sig_next  = sum.rssi;
                chan_next = sum.chan;
                n_next    = (kind_c == KIND_PROBE_REQ || kind_c == KIND_BEACON) && sum.ssid_fit
                            ? sum.ssid_n : 6'd0;
                state_next = hit ? ST_READ : ST_IDLE;
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        ap_reg   <= ap_next;
        cl_reg   <= cl_next;
        n_reg    <= n_next;
        sig_reg  <= sig_next;
        chan_reg <= chan_next;
    end

    assign rd_addr = idx_reg[AW-1:0];

    always_comb
    begin
        res.kind       = kind_reg;
        res.sig_dbm    = sig_reg;
        res.radio_chan = chan_reg;
        res.ap_mac     = ap_reg;
        res.client_mac = cl_reg;
        res.ssid_len   = n_reg;
        res.ssid_pos   = idx_reg[4:0];
        res.ssid_byte  = (n_reg != 6'd0) ? rd_data : 8'd0;
        res.run_last   = is_last;
    end

endmodule

// ===== hdl/wlan_frame_classifier.sv =====
// 802.11 frame classifier. Frames enter one byte per request on the slave
// side, frame control first, with s_tlast on the final byte; the receive
// class, signal strength and channel are latched from the first byte. A
// frame of at least 24 bytes with class management or data is classified as
// a probe request, a beacon or probe response, a deauthentication or
// disassociation, or a to-AP / from-AP data frame; anything else yields no
// result. A classified frame gives one result per captured SSID byte (up to
// SSID_MAX), or a single result when there is no SSID or it does not fit in
// the frame; m_tlast marks the final result of the frame. Bytes past
// MAX_FRAME_BYTES are accepted and ignored. Timing: one byte per cycle while
// a frame streams in. After the last byte the frame is classified, then each
// result is fetched by a registered read of the SSID RAM and presented until
// it is taken. The slave side is held off from the final byte of a frame
// until its last result is taken; a frame that yields no result holds it off
// during classification only. The SSID RAM needs no clearing after reset:
// only entries written during the current frame are ever shown.
module wlan_frame_classifier
    import wfc_pkg::*;
#(
    parameter int SSID_MAX        = 32,     // 1 .. 32
    parameter int MAX_FRAME_BYTES = 4095    // 64 .. 65535
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // data_byte[7:0], rssi[15:8], channel[23:16]
    input  logic         s_tlast,   // frame_last
    input  logic [1:0]   s_tuser,   // pkt_class[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // sig_dbm[7:0], radio_chan[15:8], ap_mac[63:16],
                                    // client_mac[111:64], ssid_len[117:112],
                                    // ssid_pos[122:118], ssid_byte[130:123], zero[135:131]
    output logic         m_tlast,   // run_last
    output logic [1:0]   m_tuser    // kind[1:0]
);

    localparam int AW = (SSID_MAX > 1) ? $clog2(SSID_MAX) : 1;

    logic          in_fire;
    logic          clear;
    frame_sum_t    sum;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    result_t       res;

    assign in_fire = s_tvalid && s_tready;

    // Header capture and element walk; SSID bytes go straight to the RAM
    wfc_parser #(
        .SSID_MAX        (SSID_MAX),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .AW              (AW)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (in_fire),
        .data_byte (s_tdata[7:0]),
        .pkt_class (s_tuser),
        .rssi      (s_tdata[15:8]),
        .channel   (s_tdata[23:16]),
        .clear     (clear),
        .sum       (sum),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    wfc_ram #(
        .WIDTH  (8),
        .DEPTH  (SSID_MAX),
        .ADDR_W (AW)
    ) u_ssid_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Classify, then walk the SSID RAM one result at a time
    wfc_emitter #(
        .SSID_MAX (SSID_MAX),
        .AW       (AW)
    ) u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_done (in_fire && s_tlast),
        .sum        (sum),
        .rd_data    (rd_data),
        .out_ready  (m_tready),
        .in_ready   (s_tready),
        .clear      (clear),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .out_valid  (m_tvalid),
        .res        (res)
    );

    assign m_tdata = {5'd0, res.ssid_byte, res.ssid_pos, res.ssid_len,
                      res.client_mac, res.ap_mac, res.radio_chan, res.sig_dbm};
    assign m_tlast = res.run_last;
    assign m_tuser = res.kind;

`ifndef ASSERT_OFF
    // Input and output phases never overlap
    a_phase_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    // The last byte of a frame holds off further input for classification
    a_hold_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input not held off after end of frame");

    // A result without SSID is the only result of its frame
    a_single_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[117:112] == 6'd0) |-> m_tlast)
        else $error("empty SSID result not marked last");

    // SSID position stays inside the captured length
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[117:112] != 6'd0) |->
            ({1'b0, m_tdata[122:118]} < m_tdata[117:112]))
        else $error("SSID position beyond captured length");
`endif

endmodule

// ===== test/tb.sv =====
module tb;
    import wfc_pkg::*;

    localparam int SSID_CAP  = 32;
    localparam int FRAME_CAP = 4095;

    // Distribution-system bits of the second frame control byte: bit 0 toDS, bit 1 fromDS.
    localparam logic [1:0] DS_NONE = 2'b00;
    localparam logic [1:0] DS_TO   = 2'b01;
    localparam logic [1:0] DS_FROM = 2'b10;
    localparam logic [1:0] DS_BOTH = 2'b11;

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
        logic [1:0] cls;
        logic [7:0] rssi;
        logic [7:0] chan;
    } byte_req_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [23:0]  s_tdata = '0;     // data_byte[7:0], rssi[15:8], channel[23:16]
    logic         s_tlast = 1'b0;   // frame_last
    logic [1:0]   s_tuser = '0;     // pkt_class[1:0]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;          // sig_dbm, radio_chan, ap_mac, client_mac,
                                    // ssid_len, ssid_pos, ssid_byte, zero pad
    logic         m_tlast;          // run_last
    logic [1:0]   m_tuser;          // kind

    wlan_frame_classifier #(
        .SSID_MAX        (SSID_CAP),
        .MAX_FRAME_BYTES (FRAME_CAP)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // Stimulus and expectations
    byte_req_t   pending_bytes[$];
    result_t     awaited_results[$];
    logic [7:0]  frame_buf[$];

    int          err_count = 0;
    int          frames_sent = 0;
    int          bytes_sent = 0;
    int          results_checked = 0;
    int          runs_done = 0;
    int          runs_by_kind[4] = '{0, 0, 0, 0};

    // Predicted classifier state
    int unsigned cnt_pos = 0;
    logic [15:0] cur_fc = '0;
    logic [47:0] cur_addr[3] = '{48'h0, 48'h0, 48'h0};
    int unsigned walk_next = 0;
    logic [15:0] walk_hdr = '0;
    logic [7:0]  ssid_mem[SSID_CAP];
    bit          ssid_found = 1'b0;
    logic [1:0]  held_cls = '0;
    logic [7:0]  held_rssi = '0;
    logic [7:0]  held_chan = '0;

    // Pacing of both sides
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    bit          quiet_in = 1'b0;
    bit          quiet_out = 1'b0;
    byte_req_t   drv_req;

    function automatic logic [7:0] rand_octet();
        int unsigned r;
        r = $urandom_range(7);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] fc_lo(input logic [3:0] sub, input logic [1:0] ftype);
        return {sub, ftype, 2'($urandom_range(3))};
    endfunction

    function automatic logic [7:0] fc_hi(input logic [1:0] ds);
        return {6'($urandom_range(63)), ds};
    endfunction

    // Mostly no gap, some short gaps, a few long, none at all during quiet stretches.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (quiet_in || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int unsigned pick_stall();
        if ($urandom_range(9) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(0, 2);
    endfunction

    // Append one byte to the frame under construction
    task automatic add_octet(input logic [7:0] b);
        frame_buf = {frame_buf, b};
    endtask

    // Start a frame: frame control, duration, three addresses, sequence control.
    task automatic put_header(input logic [7:0] lo, input logic [7:0] hi);
        frame_buf.delete();
        add_octet(lo);
        add_octet(hi);
        repeat (22) add_octet(rand_octet());
    endtask

    // Timestamp, beacon interval and capability bytes
    task automatic put_fixed();
        repeat (12) add_octet(rand_octet());
    endtask

    task automatic put_elem(input logic [7:0] id, input logic [7:0] ln, input int body);
        add_octet(id);
        add_octet(ln);
        repeat (body) add_octet(rand_octet());
    endtask

    // Queue the frame under construction as byte requests. Side fields only
    // count on the first byte, so scramble them everywhere else.
    task automatic send_frame(input logic [1:0] cls, input logic [7:0] rssi,
                              input logic [7:0] chan);
        byte_req_t req;
        for (int i = 0; i < frame_buf.size(); i++)
        begin
            req.data    = frame_buf[i];
            req.is_last = (i == frame_buf.size() - 1);
            if (i == 0)
            begin
                req.cls  = cls;
                req.rssi = rssi;
                req.chan = chan;
            end
            else
            begin
                req.cls  = 2'($urandom_range(3));
                req.rssi = 8'($urandom_range(255));
                req.chan = 8'($urandom_range(255));
            end
            pending_bytes = {pending_bytes, req};
        end
        bytes_sent += frame_buf.size();
        frames_sent++;
    endtask

    // Advance the predicted parser by one accepted byte; on the final byte,
    // classify the frame and queue the results it must produce.
    task automatic classify_byte(input logic [7:0] b, input logic is_last,
                                 input logic [1:0] cls, input logic [7:0] rssi,
                                 input logic [7:0] chan);
        int unsigned pos, len, lim, n;
        logic [3:0]  sub;
        logic [1:0]  ftype;
        kind_t       k;
        logic [47:0] ap, cl;
        bit          ok;
        result_t     r;

        if (cnt_pos == 0)
        begin
            held_cls  = cls;
            held_rssi = rssi;
            held_chan = chan;
        end
        if (cnt_pos < FRAME_CAP)
        begin
            pos = cnt_pos;
            if (pos == 0)
            begin
                cur_fc     = {8'h00, b};
                ssid_found = 1'b0;
                walk_hdr   = '0;
                sub        = b[7:4];
                if (sub == SUB_PROBE_REQ)
                    walk_next = PROBE_REQ_IES;
                else if (sub == SUB_PROBE_RESP || sub == SUB_BEACON)
                    walk_next = BEACON_IES;
                else
                    walk_next = 0;
            end
            else if (pos == 1)
            begin
                cur_fc[15:8] = b;
            end
            if (pos >= ADDR1_OFS && pos < ADDR_END)
                cur_addr[(pos - ADDR1_OFS) / 6] = {cur_addr[(pos - ADDR1_OFS) / 6][39:0], b};
            if (!ssid_found)
            begin
                // Walk element headers until the SSID element turns up.
                if (walk_next != 0)
                begin
                    if (pos == walk_next)
                    begin
                        walk_hdr = {b, 8'h00};
                    end
                    else if (pos == walk_next + 1)
                    begin
                        walk_hdr[7:0] = b;
                        if (walk_hdr[15:8] == ELEM_ID_SSID)
                        begin
                            ssid_found = 1'b1;
                            walk_next  = pos + 1;
                        end
                        else
                        begin
                            walk_next = pos + 1 + b;
                        end
                    end
                end
            end
            else
            begin
                lim = (walk_hdr[7:0] > SSID_CAP) ? SSID_CAP : walk_hdr[7:0];
                if (pos >= walk_next && pos - walk_next < lim)
                    ssid_mem[(pos - walk_next) % SSID_CAP] = b;
            end
            cnt_pos++;
        end
        if (!is_last)
            return;

        len   = cnt_pos;
        ftype = cur_fc[3:2];
        sub   = cur_fc[7:4];
        ok    = 1'b1;
        ap    = '0;
        cl    = '0;
        k     = KIND_DATA;
        if ((held_cls != CLS_MGMT && held_cls != CLS_DATA) || len < HDR_MIN_LEN)
        begin
            ok = 1'b0;
        end
        else if (ftype == FTYPE_MGMT)
        begin
            if (sub == SUB_PROBE_REQ)
            begin
                k  = KIND_PROBE_REQ;
                cl = cur_addr[1];
            end
            else if (sub == SUB_PROBE_RESP || sub == SUB_BEACON)
            begin
                k  = KIND_BEACON;
                ap = cur_addr[2];
            end
            else if (sub == SUB_DISASSOC || sub == SUB_DEAUTH)
            begin
                k  = KIND_DEAUTH;
                ap = cur_addr[1];
            end
            else
            begin
                ok = 1'b0;
            end
        end
        else if (ftype == FTYPE_DATA)
        begin
            if (cur_fc[9:8] == DS_TO)
            begin
                ap = cur_addr[0];
                cl = cur_addr[1];
            end
            else if (cur_fc[9:8] == DS_FROM)
            begin
                ap = cur_addr[1];
                cl = cur_addr[0];
            end
            else
            begin
                ok = 1'b0;
            end
        end
        else
        begin
            ok = 1'b0;
        end

        if (ok)
        begin
            n = 0;
            if ((k == KIND_PROBE_REQ || k == KIND_BEACON) && ssid_found
                && walk_next + walk_hdr[7:0] <= len)
                n = (walk_hdr[7:0] > SSID_CAP) ? SSID_CAP : walk_hdr[7:0];
            for (int i = 0; i == 0 || i < n; i++)
            begin
                r.kind       = k;
                r.sig_dbm    = held_rssi;
                r.radio_chan = held_chan;
                r.ap_mac     = ap;
                r.client_mac = cl;
                r.ssid_len   = 6'(n);
                r.ssid_pos   = (n != 0) ? 5'(i) : 5'd0;
                r.ssid_byte  = (n != 0) ? ssid_mem[i] : 8'h00;
                r.run_last   = (i + 1 >= n);
                awaited_results = {awaited_results, r};
            end
        end
        cnt_pos    = 0;
        walk_next  = 0;
        walk_hdr   = '0;
        ssid_found = 1'b0;
    endtask

    task automatic cmp_field(input string what, input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
            err_count++;
        end
    endtask

    // Driver: present the next byte request once the current one is taken,
    // after an optional gap.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if ($urandom_range(199) == 0)
                quiet_in <= !quiet_in;
            if (gap_left != 0)
            begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_bytes.size() != 0)
            begin
                drv_req = pending_bytes.pop_front();
                s_tdata  <= {drv_req.chan, drv_req.rssi, drv_req.data};
                s_tlast  <= drv_req.is_last;
                s_tuser  <= drv_req.cls;
                s_tvalid <= 1'b1;
                gap_left <= pick_gap();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result side back-pressure: short stalls mostly, an occasional long one.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if ($urandom_range(299) == 0)
                quiet_out <= !quiet_out;
            if (stall_left != 0)
            begin
                m_tready   <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if (!quiet_out && $urandom_range(99) < 20)
            begin
                m_tready   <= 1'b0;
                stall_left <= pick_stall();
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Monitor: predict from accepted bytes first, then check accepted results.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                classify_byte(s_tdata[7:0], s_tlast, s_tuser, s_tdata[15:8], s_tdata[23:16]);
            if (m_tvalid && m_tready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual kind %0d data %0h",
                             $time, m_tuser, m_tdata);
                    err_count++;
                end
                else
                begin
                    result_t want;
                    want = awaited_results.pop_front();
                    cmp_field("kind", want.kind, m_tuser);
                    cmp_field("sig_dbm", $unsigned(want.sig_dbm), m_tdata[7:0]);
                    cmp_field("radio_chan", want.radio_chan, m_tdata[15:8]);
                    cmp_field("ap_mac", want.ap_mac, m_tdata[63:16]);
                    cmp_field("client_mac", want.client_mac, m_tdata[111:64]);
                    cmp_field("ssid_len", want.ssid_len, m_tdata[117:112]);
                    cmp_field("ssid_pos", want.ssid_pos, m_tdata[122:118]);
                    cmp_field("ssid_byte", want.ssid_byte, m_tdata[130:123]);
                    cmp_field("run_last", want.run_last, m_tlast);
                    if (m_tlast)
                    begin
                        runs_done++;
                        runs_by_kind[m_tuser]++;
                    end
                end
                results_checked++;
            end
        end
    end

    initial
    begin
        // Directed frames. The first one goes out straight after reset.
        // Probe request, weakest signal (-128 dBm), channel zero, with an
        // SSID one byte longer than the capture limit.
        put_header(fc_lo(SUB_PROBE_REQ, FTYPE_MGMT), fc_hi(DS_NONE));
        put_elem(ELEM_ID_SSID, 8'd33, 33);
        send_frame(CLS_MGMT, 8'h80, 8'h00);
        // Beacon on the data class with an empty SSID, strongest signal.
        put_header(fc_lo(SUB_BEACON, FTYPE_MGMT), fc_hi(DS_BOTH));
        put_fixed();
        put_elem(ELEM_ID_SSID, 8'd0, 0);
        send_frame(CLS_DATA, 8'h7F, 8'hFF);
        // Probe request: another element first, then an SSID whose body runs
        // past the end of the frame.
        put_header(fc_lo(SUB_PROBE_REQ, FTYPE_MGMT), fc_hi(DS_NONE));
        put_elem(8'd1, 8'd0, 0);
        put_elem(ELEM_ID_SSID, 8'd10, 3);
        send_frame(CLS_MGMT, 8'($urandom_range(255)), 8'($urandom_range(255)));
        // Deauthentication of exactly the minimum length.
        put_header(fc_lo(SUB_DEAUTH, FTYPE_MGMT), fc_hi(DS_NONE));
        send_frame(CLS_MGMT, 8'($urandom_range(255)), 8'($urandom_range(255)));
        // Data frames: to the AP, from the AP, and both bits set.
        put_header(fc_lo(4'($urandom_range(15)), FTYPE_DATA), fc_hi(DS_TO));
        send_frame(CLS_DATA, 8'($urandom_range(255)), 8'($urandom_range(255)));
        put_header(fc_lo(4'($urandom_range(15)), FTYPE_DATA), fc_hi(DS_FROM));
        send_frame(CLS_DATA, 8'($urandom_range(255)), 8'($urandom_range(255)));
        put_header(fc_lo(4'($urandom_range(15)), FTYPE_DATA), fc_hi(DS_BOTH));
        send_frame(CLS_DATA, 8'($urandom_range(255)), 8'($urandom_range(255)));
        // A lone byte, far too short for a header.
        frame_buf.delete();
        add_octet(fc_lo(SUB_PROBE_REQ, FTYPE_MGMT));
        send_frame(CLS_MGMT, 8'($urandom_range(255)), 8'($urandom_range(255)));

        // Hold reset, release it away from the rising edge.
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain: every byte request taken, every predicted result seen, then
        // a quiet window to catch stray results.
        while (pending_bytes.size() != 0 || s_tvalid)
            @(negedge clk);
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);

        $display("Sent %0d frames in %0d bytes; checked %0d results over %0d classified frames.",
                 frames_sent, bytes_sent, results_checked, runs_done);
        $display("Runs by kind: probe request %0d, beacon %0d, deauth %0d, data %0d.",
                 runs_by_kind[KIND_PROBE_REQ], runs_by_kind[KIND_BEACON],
                 runs_by_kind[KIND_DEAUTH], runs_by_kind[KIND_DATA]);
        if (err_count == 0)
            $display("wlan_frame_classifier regression: pass");
        else
            $display("wlan_frame_classifier regression: fail");
        $finish;
    end

    // Watchdog, well above the slowest legal run.
    initial
    begin
        #25000000;
        $display("Timeout with %0d results still awaited.", awaited_results.size());
        $display("wlan_frame_classifier regression: fail");
        $finish;
    end

endmodule
